// File: hw/rtl/fnh_pkg.sv
`default_nettype none

package fnh_pkg;

  // Field and state widths of the hash.
  localparam int KeyW    = 31;
  localparam int ByteW   = 8;
  localparam int SeenW   = 3;
  localparam int TailLen = 4;
  localparam int RotAmt  = 5;

  typedef logic [KeyW-1:0]               key_t;
  typedef logic [ByteW-1:0]              byte_t;
  typedef logic [SeenW-1:0]              seen_t;
  typedef logic [TailLen-1:0][ByteW-1:0] tail_t;

  // The byte count stops here; it only has to tell "more than four" apart.
  localparam seen_t SeenMax = seen_t'(TailLen + 1);

  // Tails that are excluded from the key; element 0 is the oldest byte.
  localparam tail_t TailTt = '{8'h29, 8'h54, 8'h54, 8'h28};
  localparam tail_t TailPs = '{8'h29, 8'h53, 8'h50, 8'h28};

  // Rotate the key left within its width, then mix in one byte.
  function automatic key_t fold(input key_t k, input byte_t b);
    key_t rot;
    rot = {k[KeyW-RotAmt-1:0], k[KeyW-1:KeyW-RotAmt]};
    return rot ^ key_t'(b);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fnh_if.sv
`default_nettype none

// Channel carrying one name byte per beat.
interface fnh_byte_if;
  logic          valid;
  logic          ready;
  fnh_pkg::byte_t name_byte;
  logic          last_byte;

  modport source (output valid, output name_byte, output last_byte, input ready);
  modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

// Channel carrying one finished key per beat.
interface fnh_key_if;
  logic          valid;
  logic          ready;
  fnh_pkg::key_t name_key;
  logic          suffix_dropped;

  modport source (output valid, output name_key, output suffix_dropped, input ready);
  modport sink   (input valid, input name_key, input suffix_dropped, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fnh_finish.sv
`default_nettype none

// End-of-name evaluation: either drop a recognized tail or fold the held bytes.
module fnh_finish (
  input  wire fnh_pkg::key_t  key,
  input  wire fnh_pkg::tail_t tail,
  input  wire fnh_pkg::seen_t seen,
  output fnh_pkg::key_t       final_key,
  output logic                dropped
);
  import fnh_pkg::*;

  localparam int CntW = SeenW + 1;

  // A tail is only dropped when the name is longer than the tail itself.
  always_comb begin
    dropped = (seen > seen_t'(TailLen)) && ((tail == TailTt) || (tail == TailPs));
  end

  // Fold the held bytes that belong to the name, oldest first.
  always_comb begin
    final_key = key;
    for (int i = 0; i < TailLen; i++) begin
      if (!dropped && ((CntW'(seen) + CntW'(i)) >= CntW'(TailLen))) begin
        final_key = fold(final_key, tail[i]);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/family_name_hash_core.sv
// A key passes through the input register and then the output register before it is offered.
// Throughput: one byte per cycle unless the input register stalls; one key per name, on the name's last byte.
// The input register stalls only while a finished key waits in the output register.
// Reset (synchronous, active high) empties both registers and clears the hash state.
`default_nettype none

module family_name_hash_core (
  input  wire       clk,
  input  wire       rst,
  fnh_byte_if.sink  byte_in,
  fnh_key_if.source key_out
);
  import fnh_pkg::*;

  // Input register.
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_last;

  // Hash state.
  key_t  running_key;
  tail_t tail_bytes;
  seen_t bytes_seen;

  // Output register.
  logic  out_valid;
  key_t  out_key;
  logic  out_dropped;

  key_t  running_key_next;
  tail_t tail_bytes_next;
  seen_t bytes_seen_next;
  key_t  final_key;
  logic  final_dropped;
  logic  s1_advance;
  logic  out_take;

  assign out_take   = out_valid && key_out.ready;
  assign s1_advance = s1_valid && (!s1_last || !out_valid || key_out.ready);
  assign byte_in.ready = !s1_valid || s1_advance;

  // Move the delay line by one byte; the oldest byte joins the key once four are held.
  always_comb begin
    running_key_next = (bytes_seen >= seen_t'(TailLen)) ?
                       fold(running_key, tail_bytes[0]) : running_key;
    tail_bytes_next  = {s1_byte, tail_bytes[TailLen-1:1]};
    bytes_seen_next  = (bytes_seen == SeenMax) ? bytes_seen : bytes_seen + seen_t'(1);
  end

  fnh_finish u_finish (
    .key       (running_key_next),
    .tail      (tail_bytes_next),
    .seen      (bytes_seen_next),
    .final_key (final_key),
    .dropped   (final_dropped)
  );

  // Capture an incoming beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
    if (byte_in.ready && byte_in.valid) begin
      s1_byte <= byte_in.name_byte;
      s1_last <= byte_in.last_byte;
    end
  end

  // Update the hash state; a last byte starts the next name from scratch.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_key <= '0;
      tail_bytes  <= '0;
      bytes_seen  <= '0;
    end else if (s1_advance) begin
      if (s1_last) begin
        running_key <= '0;
        tail_bytes  <= '0;
        bytes_seen  <= '0;
      end else begin
        running_key <= running_key_next;
        tail_bytes  <= tail_bytes_next;
        bytes_seen  <= bytes_seen_next;
      end
    end
  end

  // Hold the finished key until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
    if (s1_advance && s1_last) begin
      out_key     <= final_key;
      out_dropped <= final_dropped;
    end
  end

  assign key_out.valid          = out_valid;
  assign key_out.name_key       = out_key;
  assign key_out.suffix_dropped = out_dropped;

endmodule

`default_nettype wire

// File: hw/rtl/fnh_checker.sv
`default_nettype none

module fnh_checker (
  input wire                clk,
  input wire                rst,
  input wire                in_valid,
  input wire                in_ready,
  input wire                last_byte,
  input wire                out_valid,
  input wire                out_ready,
  input wire fnh_pkg::key_t name_key,
  input wire                suffix_dropped
);
  import fnh_pkg::*;

  // A key that is offered stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("key beat withdrawn before it was taken");

  // A stalled key keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(name_key) && $stable(suffix_dropped))
    else $error("stalled key beat changed");

  // A newly offered key follows a last byte that was taken through the input register.
  a_key_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && last_byte, 2))
    else $error("key beat without a preceding last byte");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("key beat offered right after reset");

endmodule

bind family_name_hash_core fnh_checker u_fnh_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (byte_in.valid),
  .in_ready       (byte_in.ready),
  .last_byte      (byte_in.last_byte),
  .out_valid      (key_out.valid),
  .out_ready      (key_out.ready),
  .name_key       (key_out.name_key),
  .suffix_dropped (key_out.suffix_dropped)
);

`default_nettype wire

// File: dv/family_name_hash_core_test.sv
`default_nettype none

module family_name_hash_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fnh_pkg::*;

  localparam int  NameByteTarget = 1500;
  localparam int  CycleLimit     = 200000;
  localparam int  HoldAfterKeys  = 40;
  localparam int  HoldCycles     = 400;
  localparam int  DrainCycles    = 20;

  // Characters of the suffixes that are cut from a name.
  localparam byte_t ChOpen  = 8'h28;
  localparam byte_t ChClose = 8'h29;
  localparam byte_t ChT     = 8'h54;
  localparam byte_t ChP     = 8'h50;
  localparam byte_t ChS     = 8'h53;

  typedef struct packed {
    key_t key;
    logic dropped;
  } name_result_t;

  // One directed beat; known marks a row whose result is typed in.
  typedef struct {
    byte_t value;
    logic  is_last;
    bit    known;
    key_t  key;
    logic  dropped;
  } name_row_t;

  logic clk;
  logic rst;

  fnh_byte_if byte_ch ();
  fnh_key_if  key_ch ();

  family_name_hash_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .key_out (key_ch)
  );

  // Keys still owed by the block, oldest first.
  name_result_t expected_keys[$];
  int           fault_count  = 0;
  int           keys_checked = 0;
  int           cycle_count  = 0;

  // Mirror of the hash state.
  key_t  mirror_key;
  byte_t hash_tail[4];
  seen_t hash_seen;

  // Directed names: single bytes including both extremes, a short name that spells a
  // suffix, two long names that lose their suffix, and a long name of odd bytes.
  name_row_t name_rows[24] = '{
    '{8'h41, 1'b1, 1'b1, 31'h41, 1'b0},
    '{8'hff, 1'b1, 1'b1, 31'hff, 1'b0},
    '{8'h00, 1'b1, 1'b1, 31'h00, 1'b0},
    '{ChOpen,  1'b0, 1'b0, '0, 1'b0},
    '{ChT,     1'b0, 1'b0, '0, 1'b0},
    '{ChT,     1'b0, 1'b0, '0, 1'b0},
    '{ChClose, 1'b1, 1'b0, '0, 1'b0},
    '{8'h41,   1'b0, 1'b0, '0, 1'b0},
    '{ChOpen,  1'b0, 1'b0, '0, 1'b0},
    '{ChT,     1'b0, 1'b0, '0, 1'b0},
    '{ChT,     1'b0, 1'b0, '0, 1'b0},
    '{ChClose, 1'b1, 1'b1, 31'h41, 1'b1},
    '{8'h42,   1'b0, 1'b0, '0, 1'b0},
    '{ChOpen,  1'b0, 1'b0, '0, 1'b0},
    '{ChP,     1'b0, 1'b0, '0, 1'b0},
    '{ChS,     1'b0, 1'b0, '0, 1'b0},
    '{ChClose, 1'b1, 1'b1, 31'h42, 1'b1},
    '{8'h00, 1'b0, 1'b0, '0, 1'b0},
    '{8'h80, 1'b0, 1'b0, '0, 1'b0},
    '{8'h7f, 1'b0, 1'b0, '0, 1'b0},
    '{8'hff, 1'b0, 1'b0, '0, 1'b0},
    '{8'h55, 1'b0, 1'b0, '0, 1'b0},
    '{8'haa, 1'b0, 1'b0, '0, 1'b0},
    '{8'h01, 1'b1, 1'b0, '0, 1'b0}
  };

  int burst_left = 0;
  int bytes_sent = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Rotate left by five within the key, then mix in the byte.
  function automatic key_t rotate_mix(input key_t k, input byte_t b);
    return {k[KeyW-6:0], k[KeyW-1:KeyW-5]} ^ {{(KeyW-ByteW){1'b0}}, b};
  endfunction

  // Advance the hash mirror by one byte; returns 1 when the byte ends a name.
  function automatic bit hash_name_byte(input byte_t b, input logic is_last,
                                        output key_t key, output logic dropped);
    int first;
    key = '0;
    dropped = 1'b0;
    if (hash_seen >= 4) mirror_key = rotate_mix(mirror_key, hash_tail[0]);
    hash_tail[0] = hash_tail[1];
    hash_tail[1] = hash_tail[2];
    hash_tail[2] = hash_tail[3];
    hash_tail[3] = b;
    if (hash_seen < 5) hash_seen = hash_seen + 1'b1;
    if (!is_last) return 1'b0;

    key = mirror_key;
    if (hash_seen > 4 && hash_tail[0] == ChOpen && hash_tail[3] == ChClose &&
        ((hash_tail[1] == ChT && hash_tail[2] == ChT) ||
         (hash_tail[1] == ChP && hash_tail[2] == ChS))) begin
      dropped = 1'b1;
    end else begin
      first = (hash_seen < 4) ? 4 - int'(hash_seen) : 0;
      for (int i = first; i < 4; i++) key = rotate_mix(key, hash_tail[i]);
    end
    hash_clear();
    return 1'b1;
  endfunction

  function automatic void hash_clear();
    mirror_key = '0;
    hash_seen = '0;
    for (int i = 0; i < 4; i++) hash_tail[i] = '0;
  endfunction

  // Offer one byte, with a random gap when the current burst is used up.
  task automatic send_name_byte(input byte_t b, input logic is_last, input bit known,
                                input key_t known_key, input logic known_drop);
    key_t         key;
    logic         dropped;
    name_result_t res;
    if (burst_left == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    byte_ch.valid     <= 1'b1;
    byte_ch.name_byte <= b;
    byte_ch.last_byte <= is_last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    if (hash_name_byte(b, is_last, key, dropped)) begin
      res.key     = known ? known_key : key;
      res.dropped = known ? known_drop : dropped;
      expected_keys.push_back(res);
    end
  endtask

  // Build one random name: half are bodies with a suffix, some of them near misses,
  // the rest plain names and the occasional long one.
  task automatic build_name(output byte_t name_q[$]);
    int    kind;
    int    body_len;
    byte_t suffix[4];
    name_q = {};
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      for (int i = 0; i < body_len; i++) name_q.push_back(byte_t'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) suffix = '{ChOpen, ChT, ChT, ChClose};
      else suffix = '{ChOpen, ChP, ChS, ChClose};
      // A near miss flips one bit of the suffix.
      if (kind == 4) suffix[$urandom_range(0, 3)] ^= byte_t'(1 << $urandom_range(0, 7));
      for (int i = 0; i < 4; i++) name_q.push_back(suffix[i]);
    end else if (kind <= 8) begin
      body_len = $urandom_range(1, 12);
      for (int i = 0; i < body_len; i++) begin
        if (kind <= 6) name_q.push_back(byte_t'($urandom_range(32, 126)));
        else name_q.push_back(byte_t'($urandom_range(0, 255)));
      end
    end else begin
      body_len = $urandom_range(20, 60);
      for (int i = 0; i < body_len; i++) name_q.push_back(byte_t'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus: reset, the directed table, then random names.
  initial begin
    byte_t name_q[$];
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.name_byte = '0;
    byte_ch.last_byte = 1'b0;
    hash_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (name_rows[i]) begin
      send_name_byte(name_rows[i].value, name_rows[i].is_last, name_rows[i].known,
                     name_rows[i].key, name_rows[i].dropped);
    end

    while (bytes_sent < NameByteTarget) begin
      build_name(name_q);
      foreach (name_q[i]) begin
        send_name_byte(name_q[i], i == name_q.size() - 1, 1'b0, '0, 1'b0);
      end
    end
    byte_ch.valid <= 1'b0;

    wait (expected_keys.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fault_count == 0) begin
      $display("** family_name_hash_core: PASSED **");
    end else begin
      $display("** family_name_hash_core: FAILED **");
    end
    $finish;
  end

  // Receiver: a stall pattern that changes mode now and then, plus one long
  // hold-off so that the block backs up into its input.
  initial begin
    int  stall_mode;
    int  mode_left;
    int  hold_left;
    int  phase;
    bit  hold_done;
    stall_mode = 0;
    mode_left  = 100;
    hold_left  = 0;
    phase      = 0;
    hold_done  = 1'b0;
    key_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && keys_checked >= HoldAfterKeys) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 200);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        key_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: key_ch.ready <= 1'b1;
          1: key_ch.ready <= 1'($urandom_range(0, 1));
          2: key_ch.ready <= ($urandom_range(0, 3) == 0);
          default: key_ch.ready <= phase[0];
        endcase
      end
    end
  end

  // Compare each key beat with the oldest expectation.
  always @(posedge clk) begin
    name_result_t want;
    if (!rst && key_ch.valid && key_ch.ready) begin
      keys_checked++;
      if (expected_keys.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected key beat: name_key=%h suffix_dropped=%b",
                 $time, key_ch.name_key, key_ch.suffix_dropped);
      end else begin
        want = expected_keys.pop_front();
        if (key_ch.name_key !== want.key) begin
          fault_count++;
          $display("%0t: name_key mismatch: expected %h, actual %h",
                   $time, want.key, key_ch.name_key);
        end
        if (key_ch.suffix_dropped !== want.dropped) begin
          fault_count++;
          $display("%0t: suffix_dropped mismatch: expected %b, actual %b",
                   $time, want.dropped, key_ch.suffix_dropped);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d keys outstanding", $time, expected_keys.size());
      $display("** family_name_hash_core: FAILED **");
      $finish;
    end
  end

endmodule

`default_nettype wire
